/* sv/imuf_pkg.sv */
package imuf_pkg;

  // Frame format
  localparam int FRAME_LENGTH = 11;
  localparam int ByteIdxW = $clog2(FRAME_LENGTH);
  localparam logic [7:0] HEADER_BYTE = 8'h55;
  localparam logic [7:0] TYPE_ACCEL = 8'h51;
  localparam logic [7:0] TYPE_GYRO = 8'h52;

  // Byte positions inside a frame
  localparam logic [ByteIdxW-1:0] POS_TYPE = ByteIdxW'(1);
  localparam logic [ByteIdxW-1:0] POS_ACC_LO = ByteIdxW'(2);
  localparam logic [ByteIdxW-1:0] POS_ACC_HI = ByteIdxW'(3);
  localparam logic [ByteIdxW-1:0] POS_GYRO_LO = ByteIdxW'(4);
  localparam logic [ByteIdxW-1:0] POS_GYRO_HI = ByteIdxW'(5);
  localparam logic [ByteIdxW-1:0] POS_LAST = ByteIdxW'(FRAME_LENGTH - 1);

  localparam logic [15:0] GYRO_THRESHOLD_RESET = 16'd6553;

  // Queue between parser and angle pipeline
  localparam int FIFO_DEPTH = 4;
  localparam int FifoPtrW = $clog2(FIFO_DEPTH);
  localparam int FifoCntW = $clog2(FIFO_DEPTH + 1);

  // asin lookup
  localparam int ASIN_TABLE_ENTRIES = 1024;
  localparam int AsinIdxW = $clog2(ASIN_TABLE_ENTRIES);
  localparam int AsinW = 13;          // max entry is 90 deg * 64 = 5760
  localparam int MagW = 12;           // |a| saturated to 2048
  localparam int AngleW = 15;
  localparam logic [MagW-1:0] MAG_LIMIT = 12'd2048;
  localparam logic [AngleW-1:0] ANGLE_90_Q6 = 15'd5760;
  localparam logic [AngleW-1:0] ANGLE_270_Q6 = 15'd17280;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  // Table build scaling: radians Q30 to deg*64 is *18336 / (5 << 30)
  localparam logic [63:0] DEG_Q6_DEN = 64'd5 << 30;
  localparam logic [63:0] DEG_Q6_HALF = 64'd5 << 29;
  localparam logic [63:0] ASIN_STEPS = 64'(ASIN_TABLE_ENTRIES - 1);

  typedef struct packed {
    logic signed [15:0] sample;
    logic               phase;
    logic [15:0]        distance;
  } frame_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  typedef logic [AsinW-1:0] asin_rom_t [ASIN_TABLE_ENTRIES];

  // Q30 sine, Taylor series to x^17, truncating each step
  function automatic logic [63:0] sine_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd272;
    sum = sum + longint'(term);
    return (sum < 0) ? 64'd0 : 64'(sum);
  endfunction

  // Bisection for the largest theta with sine(theta) <= ratio, scaled to deg*64
  function automatic logic [AsinW-1:0] asin_q6(input logic [63:0] ratio_q30);
    logic [63:0] lo;
    logic [63:0] cand;
    lo = 64'd0;
    for (int b = 30; b >= 0; b--) begin
      cand = lo | (64'd1 << b);
      if (cand <= HALF_PI_Q30 && sine_q30(cand) <= ratio_q30) begin
        lo = cand;
      end
    end
    return AsinW'((lo * 64'd18336 + DEG_Q6_HALF) / DEG_Q6_DEN);
  endfunction

  function automatic asin_rom_t build_asin_rom();
    asin_rom_t rom;
    for (int j = 0; j < ASIN_TABLE_ENTRIES; j++) begin
      rom[j] = asin_q6((64'(j) * ONE_Q30) / ASIN_STEPS);
    end
    return rom;
  endfunction

endpackage

/* sv/imuf_fifo.sv */
module imuf_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  imuf_pkg::frame_item_t push_item,
  input  logic                  pop,
  output imuf_pkg::frame_item_t head_item,
  output imuf_pkg::fifo_status_t status
);

  imuf_pkg::frame_item_t entries [imuf_pkg::FIFO_DEPTH];
  logic [imuf_pkg::FifoPtrW-1:0] wr_ptr;
  logic [imuf_pkg::FifoPtrW-1:0] rd_ptr;
  logic [imuf_pkg::FifoCntW-1:0] count;

  localparam logic [imuf_pkg::FifoCntW-1:0] Full =
    imuf_pkg::FifoCntW'(imuf_pkg::FIFO_DEPTH);
  localparam logic [imuf_pkg::FifoPtrW-1:0] LastPtr =
    imuf_pkg::FifoPtrW'(imuf_pkg::FIFO_DEPTH - 1);

  assign status.full = (count == Full);
  assign status.empty = (count == '0);
  assign head_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

/* sv/imuf_front.sv */
module imuf_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             rx_byte,
  input  logic                   cfg_wen,
  input  logic [15:0]            cfg_wdata,
  input  imuf_pkg::fifo_status_t fifo_status,
  output logic                   push,
  output imuf_pkg::frame_item_t  push_item
);

  logic [imuf_pkg::ByteIdxW-1:0] byte_index;
  logic [7:0] frame_type;
  logic [7:0] acc_lo;
  logic [7:0] acc_hi;
  logic [7:0] gyro_lo;
  logic [7:0] gyro_hi;

  logic signed [15:0] gyro_threshold;
  logic signed [15:0] gyro_y;
  logic signed [15:0] accel_older;
  logic signed [15:0] accel_newer;
  logic               phase_flag;
  logic [15:0]        distance;

  logic               accept;
  logic               hunting;
  logic               frame_done;
  logic signed [15:0] sample;
  logic               valley;
  logic               peak;
  logic               phase_flag_next;
  logic [15:0]        distance_next;

  assign in_stall = fifo_status.full;
  assign accept = in_valid && !in_stall;
  assign hunting = (byte_index == '0) && (rx_byte != imuf_pkg::HEADER_BYTE);
  assign frame_done = accept && !hunting && (byte_index == imuf_pkg::POS_LAST);
  assign sample = $signed({acc_hi, acc_lo});

  // valley clears, then peak sets: a flat run ends set
  always_comb begin
    valley = (accel_older >= accel_newer) && (accel_newer <= sample);
    peak = (accel_older <= accel_newer) && (accel_newer >= sample);
    phase_flag_next = phase_flag;
    distance_next = distance;
    if (valley) begin
      phase_flag_next = 1'b0;
    end
    if (peak) begin
      phase_flag_next = 1'b1;
      if (gyro_y > gyro_threshold) begin
        distance_next = distance + 16'd1;
      end
    end
  end

  assign push = frame_done && (frame_type == imuf_pkg::TYPE_ACCEL);
  assign push_item.sample = sample;
  assign push_item.phase = phase_flag_next;
  assign push_item.distance = distance_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
      gyro_threshold <= imuf_pkg::GYRO_THRESHOLD_RESET;
      gyro_y <= '0;
      accel_older <= '0;
      accel_newer <= '0;
      phase_flag <= 1'b0;
      distance <= '0;
    end else begin
      if (cfg_wen) begin
        gyro_threshold <= cfg_wdata;
      end
      if (accept && !hunting) begin
        byte_index <= (byte_index == imuf_pkg::POS_LAST) ? '0 : byte_index + 1'b1;
      end
      if (frame_done) begin
        if (frame_type == imuf_pkg::TYPE_GYRO) begin
          gyro_y <= $signed({gyro_hi, gyro_lo});
        end
        if (frame_type == imuf_pkg::TYPE_ACCEL) begin
          accel_older <= accel_newer;
          accel_newer <= sample;
          phase_flag <= phase_flag_next;
          distance <= distance_next;
        end
      end
    end
  end

  // frame bytes, only the ones that matter are kept
  always_ff @(posedge clk) begin
    if (accept && !hunting) begin
      case (byte_index)
        imuf_pkg::POS_TYPE:    frame_type <= rx_byte;
        imuf_pkg::POS_ACC_LO:  acc_lo <= rx_byte;
        imuf_pkg::POS_ACC_HI:  acc_hi <= rx_byte;
        imuf_pkg::POS_GYRO_LO: gyro_lo <= rx_byte;
        imuf_pkg::POS_GYRO_HI: gyro_hi <= rx_byte;
        default: ;
      endcase
    end
  end

endmodule

/* sv/imuf_back.sv */
module imuf_back (
  input  logic                  clk,
  input  logic                  rst,
  input  imuf_pkg::frame_item_t head_item,
  input  logic                  head_valid,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [14:0]           angle_q6,
  output logic [15:0]           distance_count,
  output logic                  peak_phase,
  output logic signed [15:0]    accel_x
);

  localparam imuf_pkg::asin_rom_t AsinRom = imuf_pkg::build_asin_rom();
  localparam int ProdW = imuf_pkg::MagW + imuf_pkg::AsinIdxW + 1;
  localparam logic [ProdW-1:0] Scale = ProdW'(imuf_pkg::ASIN_TABLE_ENTRIES - 1);
  localparam logic [ProdW-1:0] Half = ProdW'(1024);
  localparam logic [ProdW-1:0] LastIdx = ProdW'(imuf_pkg::ASIN_TABLE_ENTRIES - 1);

  // stage 1: table index
  logic                          v1;
  logic [imuf_pkg::AsinIdxW-1:0] idx1;
  logic                          neg1;
  imuf_pkg::frame_item_t         item1;
  // stage 2: table read
  logic                          v2;
  logic [imuf_pkg::AsinW-1:0]    rom_q;
  logic                          neg2;
  imuf_pkg::frame_item_t         item2;

  logic                          adv1;
  logic                          adv2;
  logic                          adv3;
  logic [16:0]                   abs_val;
  logic [imuf_pkg::MagW-1:0]     mag;
  logic [ProdW-1:0]              prod;
  logic [ProdW-1:0]              idx_wide;
  logic [imuf_pkg::AsinIdxW-1:0] idx_next;
  logic [14:0]                   t;
  logic [14:0]                   angle_next;

  assign adv3 = !out_valid || !out_stall;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign pop = head_valid && adv1;

  always_comb begin
    abs_val = head_item.sample[15] ? 17'(-$signed({1'b1, head_item.sample}))
                                   : {1'b0, head_item.sample};
    mag = (abs_val > 17'(imuf_pkg::MAG_LIMIT)) ? imuf_pkg::MAG_LIMIT
                                                : abs_val[imuf_pkg::MagW-1:0];
    prod = ProdW'(mag) * Scale + Half;
    idx_wide = prod >> 11;
    idx_next = (idx_wide > LastIdx) ? LastIdx[imuf_pkg::AsinIdxW-1:0]
                                    : idx_wide[imuf_pkg::AsinIdxW-1:0];
  end

  always_comb begin
    t = 15'(rom_q);
    if (item2.phase) begin
      angle_next = neg2 ? imuf_pkg::ANGLE_90_Q6 - t : imuf_pkg::ANGLE_90_Q6 + t;
    end else begin
      angle_next = neg2 ? imuf_pkg::ANGLE_270_Q6 + t : imuf_pkg::ANGLE_270_Q6 - t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= head_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv3) begin
        out_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      idx1 <= idx_next;
      neg1 <= head_item.sample[15];
      item1 <= head_item;
    end
    if (adv2 && v1) begin
      rom_q <= AsinRom[idx1];
      neg2 <= neg1;
      item2 <= item1;
    end
    if (adv3 && v2) begin
      angle_q6 <= angle_next;
      distance_count <= item2.distance;
      peak_phase <= item2.phase;
      accel_x <= item2.sample;
    end
  end

endmodule

/* sv/imu_frame_peak_angle_tracker.sv */
// Channel   Signals                                        Transaction
// input     in_valid, in_stall, rx_byte                    one serial byte
// output    out_valid, out_stall, angle_q6, distance_count,  one angle result
//           peak_phase, accel_x                            per accel frame
// config    cfg_wen, cfg_wdata                             gyro_threshold write
//
// One byte is taken per cycle while in_stall is low; the parser updates its
// frame state in the accepting cycle, so bytes can stream with no gaps.
// After the queue is written on the edge that takes the last byte of an accel
// frame, its angle passes through the index register, the registered asin
// ROM read and the output register.
// rst is synchronous; it clears the parser, history, counters, queue and
// pipeline valids and loads gyro_threshold with 6553.
// in_stall rises only while the four-entry queue is full; the angle pipeline
// holds on out_stall and keeps draining otherwise.
module imu_frame_peak_angle_tracker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               cfg_wen,
  input  logic [15:0]        cfg_wdata,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [14:0]        angle_q6,
  output logic [15:0]        distance_count,
  output logic               peak_phase,
  output logic signed [15:0] accel_x
);

  // parser -> queue
  logic                   push;
  imuf_pkg::frame_item_t  push_item;
  imuf_pkg::fifo_status_t fifo_status;
  // queue -> angle pipeline
  logic                   pop;
  imuf_pkg::frame_item_t  head_item;

  // Front end: header hunt, byte assembly, history, phase and distance
  imuf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .fifo_status (fifo_status),
    .push        (push),
    .push_item   (push_item)
  );

  // Decouples the parser from a stalled result consumer
  imuf_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .status    (fifo_status)
  );

  // Back end: asin lookup and angle formation
  imuf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_item      (head_item),
    .head_valid     (!fifo_status.empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .angle_q6       (angle_q6),
    .distance_count (distance_count),
    .peak_phase     (peak_phase),
    .accel_x        (accel_x)
  );

endmodule
